/* design/clis_pkg.sv */
// ----------------------------------------------------------------------------
// clis_pkg
// Shared types, constants and helpers for the case-insensitive letter sorter.
// ----------------------------------------------------------------------------
package clis_pkg;

  // default number of characters held per set
  localparam int CAPACITY_DEF   = 32;
  localparam int LETTER_W       = 7;
  // codes above this limit are folded down by the case offset
  localparam logic [LETTER_W-1:0] KEY_FOLD_LIMIT = 7'd91;
  localparam logic [LETTER_W-1:0] CASE_OFFSET    = 7'd32;

  typedef logic [LETTER_W-1:0] letter_t;

  // input request payload
  typedef struct packed {
    letter_t letter;
    logic    final_item;
  } in_item_t;

  // result payload
  typedef struct packed {
    letter_t sorted_letter;
    logic    run_end;
    logic    overflowed;
  } out_item_t;

  // controller states
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } clis_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // take the request letter (insert or drop)
    logic pop;    // emit the head of the sorted chain
  } clis_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_one;  // exactly one character left in the chain
  } clis_stat_t;

  // case-insensitive sort key
  function automatic letter_t sort_key(input letter_t code);
    letter_t k;
    k = (code > KEY_FOLD_LIMIT) ? (code - CASE_OFFSET) : code;
    return k;
  endfunction

endpackage

/* design/case_insensitive_letter_sorter_core.sv */
// ----------------------------------------------------------------------------
// case_insensitive_letter_sorter_core
// Collects characters and returns them in stable case-insensitive order.
// ----------------------------------------------------------------------------
// Loading: one request per cycle when not busy, sorted in on the same cycle.
// A final request starts a drain of n results (n = stored count, 1..CAPACITY),
// one per cycle from the head of the insertion chain; first result strobes
// after the state and result registers; busy stays high through the pops.
// The receiver cannot stall; results are strobed for one cycle each.
// Reset (synchronous, active low) empties the chain and clears the drop flag.
module case_insensitive_letter_sorter_core
  import clis_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  clis_cmd_t  cmd;
  clis_stat_t stat;

  // controller
  clis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .final_item (in_item.final_item),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  // datapath
  clis_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_letter (in_item.letter),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* design/clis_ctrl.sv */
// ----------------------------------------------------------------------------
// clis_ctrl
// Load/drain state machine; issues load and pop commands to the datapath.
// ----------------------------------------------------------------------------
module clis_ctrl
  import clis_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       final_item,
  input  clis_stat_t stat,
  output logic       busy,
  output clis_cmd_t  cmd
);

  clis_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        cmd.load = start;
        if (start && final_item) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        busy    = 1'b1;
        cmd.pop = 1'b1;
        if (stat.last_one) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

/* design/clis_dp.sv */
// ----------------------------------------------------------------------------
// clis_dp
// Sorted insertion chain with fill count, drop flag and result register.
// ----------------------------------------------------------------------------
module clis_dp
  import clis_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  clis_cmd_t  cmd,
  input  letter_t    in_letter,
  output clis_stat_t stat,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  letter_t    cell_r   [CAPACITY];
  letter_t    cell_nxt [CAPACITY];
  logic [CAPACITY-1:0] sh;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic       drop_r, drop_nxt;
  logic       full;
  letter_t    new_key;
  logic       out_valid_r;
  out_item_t  out_item_r;

  assign full          = (count_r == CNT_W'(CAPACITY));
  assign new_key       = sort_key(in_letter);
  assign stat.last_one = (count_r == CNT_W'(1));

  // per-cell shift enable: cells from the insertion point up to the fill count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      sh[i] = (CNT_W'(i) == count_r) ||
              ((CNT_W'(i) < count_r) && (sort_key(cell_r[i]) > new_key));
    end
  end

  // chain next values: insert on load, shift toward the head on pop
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.pop) begin
        if (i < CAPACITY - 1) begin
          cell_nxt[i] = cell_r[i+1];
        end
      end else if (cmd.load && !full && sh[i]) begin
        if (i == 0) begin
          cell_nxt[i] = in_letter;
        end else if (!sh[i-1]) begin
          cell_nxt[i] = in_letter;
        end else begin
          cell_nxt[i] = cell_r[i-1];
        end
      end
    end
  end

  // fill count and drop flag
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
      if (stat.last_one) begin
        drop_nxt = 1'b0;
      end
    end else if (cmd.load) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // chain storage (payload, no reset)
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= cmd.pop;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_item_r.sorted_letter <= cell_r[0];
      out_item_r.run_end       <= stat.last_one;
      out_item_r.overflowed    <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* design/clis_checker.sv */
// ----------------------------------------------------------------------------
// clis_checker
// Port-level checks on request/result sequencing of the sorter core.
// ----------------------------------------------------------------------------
module clis_checker
  import clis_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // a final request always starts a drain
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.final_item) |=> busy)
    else $error("final request did not start a drain");

  // busy only rises after a final request
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_item.final_item))
    else $error("busy rose without a final request");

  // results continue while the run is open
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.run_end) |-> busy)
    else $error("run ended without run_end");

  // the last result leaves the block ready for a new set
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.run_end) |-> !busy)
    else $error("still busy after run_end");

endmodule

bind case_insensitive_letter_sorter_core clis_checker u_clis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
